>>> hw/rtl/sigmoid_progress_weight_defines.svh
// Assertion macros for the sigmoid progress weight block.
// Used by modules that check their own pipeline; expects i_clk and i_rst_n in scope.
`ifndef SIGMOID_PROGRESS_WEIGHT_DEFINES_SVH
`define SIGMOID_PROGRESS_WEIGHT_DEFINES_SVH

// same-cycle implication
`define SPW_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/spw_pkg.sv
// Shared constants, types and constant functions for the sigmoid progress weight block.
// No dependencies.
`timescale 1ns / 1ps

package spw_pkg;

    localparam int LUT_BITS = 10;                 // fraction bits of log2 / exp2
    localparam int LOG_W    = LUT_BITS + 4;       // unsigned log2 of a 16-bit value
    localparam int M_W      = 31;                 // log2 mantissa, Q1.30
    localparam int E_W      = 31;                 // exp2 value, Q1.30
    localparam int Q_BITS   = 17;                 // weight quotient, Q0.16 up to 1.0
    localparam int D_W      = 63;                 // divisor 2^30 + scaled exp2
    localparam int N_W      = 62;                 // dividend 2^46 + D/2
    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [16:0] HALF_Q16 = 17'h08000;

    // register indexes of the config channel
    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_FIXED = 3'd1;
    localparam logic [2:0] CFG_MIN   = 3'd2;
    localparam logic [2:0] CFG_MAX   = 3'd3;
    localparam logic [2:0] CFG_MID   = 3'd4;
    localparam logic [2:0] CFG_POW   = 3'd5;
    localparam logic [2:0] CFG_RSVD6 = 3'd6;
    localparam logic [2:0] CFG_RSVD7 = 3'd7;

    typedef struct packed {
        logic        spec;    // weight forced, curve result ignored
        logic [16:0] wspec;   // forced weight, Q0.16
    } t_side;

    // bitwise integer square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        rem  = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q1.30, each root taken from the previous one
    function automatic logic [E_W-1:0] root_const(input int k);
        logic [63:0] c;
        c = 64'h8000_0000;
        for (int j = 1; j <= k; j++) begin
            c = isqrt64(c << 30);
        end
        return c[E_W-1:0];
    endfunction

endpackage

>>> hw/rtl/spw_log2.sv
// Pipelined log2 of a 16-bit unsigned value, LUT_BITS fraction bits by repeated squaring.
// Depends on spw_pkg. Fully pipelined with no stall, one value per cycle.
`timescale 1ns / 1ps

module spw_log2 (
    input  logic                        i_clk,
    input  logic [15:0]                 i_x,
    output logic [spw_pkg::LOG_W-1:0]   o_log
);

    localparam int LB = spw_pkg::LUT_BITS;

    logic [3:0]              r_e [0:LB];
    logic [spw_pkg::M_W-1:0] r_m [0:LB];
    logic [LB-1:0]           r_f [0:LB];

    logic [15:0] w_x;
    logic [3:0]  w_lead;

    // zero input is taken as one
    always_comb begin
        w_x    = (i_x == 16'd0) ? 16'd1 : i_x;
        w_lead = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (w_x[i]) w_lead = 4'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        r_e[0] <= w_lead;
        r_m[0] <= spw_pkg::M_W'({15'd0, w_x} << (5'd30 - {1'b0, w_lead}));
        r_f[0] <= '0;
    end

    for (genvar k = 1; k <= LB; k++) begin : g_sq
        logic [2*spw_pkg::M_W-1:0] w_sq;
        logic [31:0]               w_s;
        assign w_sq = r_m[k-1] * r_m[k-1];
        assign w_s  = w_sq[61:30];
        always_ff @(posedge i_clk) begin
            r_e[k] <= r_e[k-1];
            r_m[k] <= w_s[31] ? w_s[31:1] : w_s[30:0];
            r_f[k] <= {r_f[k-1][LB-2:0], w_s[31]};
        end
    end

    assign o_log = {r_e[LB], r_f[LB]};

endmodule

>>> hw/rtl/spw_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the logistic weight.
// Depends on spw_pkg; quotient must fit Q_BITS bits.
`timescale 1ns / 1ps

module spw_div (
    input  logic                        i_clk,
    input  logic [spw_pkg::N_W-1:0]     i_num,
    input  logic [spw_pkg::D_W-1:0]     i_den,
    output logic [spw_pkg::Q_BITS-1:0]  o_quot
);

    localparam int QB = spw_pkg::Q_BITS;
    localparam int DW = spw_pkg::D_W;

    logic [DW-1:0] r_r [0:QB-1];
    logic [DW-1:0] r_d [0:QB-1];
    logic [QB-1:0] r_n [0:QB-1];
    logic [QB-1:0] r_q [0:QB-1];

    for (genvar j = 0; j < QB; j++) begin : g_st
        logic [DW-1:0] w_r;
        logic [DW-1:0] w_d;
        logic [QB-1:0] w_n;
        logic [QB-1:0] w_q;
        logic [DW:0]   w_t;
        logic          w_ge;
        if (j == 0) begin : g_first
            // upper dividend bits are already below the divisor
            assign w_r = DW'(i_num >> QB);
            assign w_d = i_den;
            assign w_n = i_num[QB-1:0];
            assign w_q = '0;
        end else begin : g_next
            assign w_r = r_r[j-1];
            assign w_d = r_d[j-1];
            assign w_n = r_n[j-1];
            assign w_q = r_q[j-1];
        end
        assign w_t  = {w_r, w_n[QB-1-j]};
        assign w_ge = (w_t >= {1'b0, w_d});
        always_ff @(posedge i_clk) begin
            r_r[j] <= w_ge ? DW'(w_t - {1'b0, w_d}) : DW'(w_t);
            r_d[j] <= w_d;
            r_n[j] <= w_n;
            r_q[j] <= w_q | (QB'(w_ge) << (QB-1-j));
        end
    end

    assign o_quot = r_q[QB-1];

endmodule

>>> hw/rtl/sigmoid_progress_weight.sv
// Top level: progress to weight, fixed or logistic curve min + w*(max-min) in Q3.12.
// Depends on spw_pkg, spw_log2, spw_div and sigmoid_progress_weight_defines.svh.
//
//   channel   direction  handshake                    payload
//   item in   in         start high, busy low         i_progress
//   result    out        o_weight_valid strobe        o_weight_out
//   config    in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item per cycle; busy stays low. The result delay is set by the squaring stages of
// the log2 lanes, the exp2 root multiplies and the 17-stage quotient pipeline.
// Synchronous active-low reset clears the valid pipeline and sets the config registers to their defaults.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`include "sigmoid_progress_weight_defines.svh"

module sigmoid_progress_weight (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [16:0] i_progress,
    output logic        o_weight_valid,
    output logic [15:0] o_weight_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam int LB   = spw_pkg::LUT_BITS;
    localparam int LW   = LB + 6;          // signed log ratio
    localparam int TW   = LW + 16;         // signed exponent t
    localparam int SH   = LB + 12;         // fraction bits of t
    localparam int NW   = TW - SH;         // integer bits of t
    localparam int I_LG = LB + 1;
    localparam int I_L  = I_LG + 1;
    localparam int I_T  = I_L + 1;
    localparam int I_N  = I_T + 1;
    localparam int I_D  = I_N + LB + 1;
    localparam int I_Q  = I_D + spw_pkg::Q_BITS;
    localparam int I_W  = I_Q + 1;
    localparam int I_P  = I_W + 1;
    localparam int TOT  = I_P + 1;

    localparam logic signed [NW-1:0] N_MAX = NW'(31);
    localparam logic signed [NW-1:0] N_MIN = -NW'(32);

    // configuration
    logic        r_mode;
    logic [15:0] r_fixed;
    logic [15:0] r_min;
    logic [15:0] r_max;
    logic [16:0] r_mid;
    logic [15:0] r_pow;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_fixed <= 16'd4096;
            r_min   <= 16'd0;
            r_max   <= 16'd4096;
            r_mid   <= 17'd32768;
            r_pow   <= 16'd4096;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                spw_pkg::CFG_MODE:  r_mode  <= i_cfg_data[0];
                spw_pkg::CFG_FIXED: r_fixed <= i_cfg_data[15:0];
                spw_pkg::CFG_MIN:   r_min   <= i_cfg_data[15:0];
                spw_pkg::CFG_MAX:   r_max   <= i_cfg_data[15:0];
                spw_pkg::CFG_MID:   r_mid   <= i_cfg_data;
                spw_pkg::CFG_POW:   r_pow   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // pipeline valid and side info
    logic [TOT:0]   r_vld;
    spw_pkg::t_side r_sd [0:I_Q];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOT-1:0], start & ~busy};
        end
    end

    // input stage and forced-weight cases
    logic [16:0]    w_pc;
    logic [16:0]    w_lc;
    logic           w_pos;
    spw_pkg::t_side w_side0;
    logic [16:0]    r_p;

    always_comb begin
        w_pc  = (i_progress > spw_pkg::ONE_Q16) ? spw_pkg::ONE_Q16 : i_progress;
        w_lc  = (r_mid > spw_pkg::ONE_Q16) ? spw_pkg::ONE_Q16 : r_mid;
        w_pos = !r_pow[15] && (r_pow != 16'd0);
        w_side0.spec  = 1'b0;
        w_side0.wspec = '0;
        if (w_pc == 17'd0 || w_lc == spw_pkg::ONE_Q16) begin
            w_side0.spec  = 1'b1;
            w_side0.wspec = w_pos ? 17'd0 : spw_pkg::ONE_Q16;
        end else if (w_pc == spw_pkg::ONE_Q16 || w_lc == 17'd0) begin
            w_side0.spec  = 1'b1;
            w_side0.wspec = w_pos ? spw_pkg::ONE_Q16 :
                            (r_pow[15] ? 17'd0 : spw_pkg::HALF_Q16);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p     <= w_pc;
        r_sd[0] <= w_side0;
    end

    // four log2 lanes: loc, 1-p, p, 1-loc
    logic [16:0]               w_one_p;
    logic [16:0]               w_one_l;
    logic [spw_pkg::LOG_W-1:0] w_la;
    logic [spw_pkg::LOG_W-1:0] w_lb;
    logic [spw_pkg::LOG_W-1:0] w_lc2;
    logic [spw_pkg::LOG_W-1:0] w_ld;

    assign w_one_p = spw_pkg::ONE_Q16 - r_p;
    assign w_one_l = spw_pkg::ONE_Q16 - w_lc;

    spw_log2 u_log_loc  (.i_clk(i_clk), .i_x(w_lc[15:0]),    .o_log(w_la));
    spw_log2 u_log_onep (.i_clk(i_clk), .i_x(w_one_p[15:0]), .o_log(w_lb));
    spw_log2 u_log_p    (.i_clk(i_clk), .i_x(r_p[15:0]),     .o_log(w_lc2));
    spw_log2 u_log_onel (.i_clk(i_clk), .i_x(w_one_l[15:0]), .o_log(w_ld));

    // log ratio and exponent
    logic signed [LW-1:0] r_l;
    logic signed [TW-1:0] r_t;

    always_ff @(posedge i_clk) begin
        r_l <= $signed(LW'(w_la)) + $signed(LW'(w_lb))
             - $signed(LW'(w_lc2)) - $signed(LW'(w_ld));
        r_t <= $signed(r_pow) * r_l;
    end

    // integer/fraction split; large exponent forces zero weight
    logic signed [NW-1:0] w_nf;
    logic signed [NW-1:0] w_nc;
    spw_pkg::t_side       w_side_n;

    always_comb begin
        w_nf     = r_t[TW-1:SH];
        w_nc     = (w_nf < N_MIN) ? N_MIN : w_nf;
        w_side_n = r_sd[I_N-1];
        if (!w_side_n.spec && (w_nf > N_MAX)) begin
            w_side_n.spec  = 1'b1;
            w_side_n.wspec = 17'd0;
        end
    end

    for (genvar g = 1; g <= I_Q; g++) begin : g_side
        if (g == I_N) begin : g_upd
            always_ff @(posedge i_clk) r_sd[g] <= w_side_n;
        end else begin : g_pass
            always_ff @(posedge i_clk) r_sd[g] <= r_sd[g-1];
        end
    end

    // exp2 of the fraction: one root multiply per stage
    logic [spw_pkg::E_W-1:0] r_xe [0:LB];
    logic [6:0]              r_xn [0:LB];
    logic [LB-1:0]           r_xf [0:LB];

    always_ff @(posedge i_clk) begin
        r_xe[0] <= spw_pkg::E_W'(32'h4000_0000);
        r_xn[0] <= w_nc[6:0];
        r_xf[0] <= r_t[SH-1:12];
    end

    for (genvar k = 1; k <= LB; k++) begin : g_exp
        localparam logic [spw_pkg::E_W-1:0] C_K = spw_pkg::root_const(k);
        logic [61:0] w_pr;
        assign w_pr = r_xe[k-1] * C_K + 62'h2000_0000;
        always_ff @(posedge i_clk) begin
            r_xe[k] <= r_xf[k-1][LB-k] ? w_pr[60:30] : r_xe[k-1];
            r_xn[k] <= r_xn[k-1];
            r_xf[k] <= r_xf[k-1];
        end
    end

    // divisor 1 + 2^t and rounded dividend
    logic [spw_pkg::D_W-1:0] w_sh;
    logic [spw_pkg::D_W-1:0] w_d;
    logic [6:0]              w_neg;
    logic [spw_pkg::D_W-1:0] r_d;
    logic [spw_pkg::N_W-1:0] r_num;

    always_comb begin
        w_neg = ~r_xn[LB] + 7'd1;
        if (!r_xn[LB][6]) begin
            w_sh = {32'd0, r_xe[LB]} << r_xn[LB][4:0];
        end else begin
            w_sh = {32'd0, r_xe[LB]} >> w_neg[5:0];
        end
        w_d = spw_pkg::D_W'(64'h4000_0000) + w_sh;
    end

    always_ff @(posedge i_clk) begin
        r_d   <= w_d;
        r_num <= spw_pkg::N_W'(64'h4000_0000_0000) + spw_pkg::N_W'(w_d >> 1);
    end

    logic [spw_pkg::Q_BITS-1:0] w_quot;

    spw_div u_div (.i_clk(i_clk), .i_num(r_num), .i_den(r_d), .o_quot(w_quot));

    // blend between min and max, round, saturate; fixed mode passes r_fixed
    logic [16:0]          r_w;
    logic signed [34:0]   r_prod;
    logic signed [16:0]   w_diff;
    logic signed [35:0]   w_pb;
    logic signed [20:0]   w_res;
    logic [15:0]          r_out;

    assign w_diff = $signed({r_max[15], r_max}) - $signed({r_min[15], r_min});

    always_ff @(posedge i_clk) begin
        r_w    <= r_sd[I_Q].spec ? r_sd[I_Q].wspec : w_quot;
        r_prod <= $signed({1'b0, r_w}) * w_diff;
    end

    always_comb begin
        w_pb  = $signed({r_prod[34], r_prod}) + 36'sd32768;
        w_res = $signed({{5{r_min[15]}}, r_min}) + $signed({w_pb[35], w_pb[35:16]});
    end

    always_ff @(posedge i_clk) begin
        if (!r_mode) begin
            r_out <= r_fixed;
        end else if (w_res > 21'sd32767) begin
            r_out <= 16'h7FFF;
        end else if (w_res < -21'sd32768) begin
            r_out <= 16'h8000;
        end else begin
            r_out <= w_res[15:0];
        end
    end

    assign o_weight_valid = r_vld[TOT];
    assign o_weight_out   = r_out;

    logic w_spec_in;
    assign w_spec_in = r_vld[I_N-1] && r_sd[I_N-1].spec;

    `SPW_ASSERT_IMPL(a_latency, o_weight_valid, $past(start, TOT + 1), "result without transfer")
    `SPW_ASSERT_IMPL(a_quot_range, r_vld[I_Q], w_quot <= spw_pkg::ONE_Q16, "quotient above one")
    `SPW_ASSERT_NEXT(a_spec_hold, w_spec_in, r_sd[I_N] == $past(r_sd[I_N-1]), "forced weight lost")

endmodule

>>> tb/sv/testbench.sv
// Testbench for sigmoid_progress_weight: directed and random progress values under
// several register settings, checked against a built-in predictor. Depends on the RTL only.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC_BITS = 10;
    localparam int LATENCY   = 46;
    localparam int WDOG_MAX  = 5000;
    localparam logic [16:0] Q16_ONE = 17'h10000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [16:0] i_progress = '0;
    logic        o_weight_valid;
    logic [15:0] o_weight_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = spw_pkg::CFG_MODE;
    logic [16:0] i_cfg_data = '0;

    sigmoid_progress_weight dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor copy of the registers
    logic        cur_mode  = 1'b1;
    logic [15:0] cur_fixed = 16'd4096;
    logic [15:0] cur_min   = 16'd0;
    logic [15:0] cur_max   = 16'd4096;
    logic [16:0] cur_mid   = 17'd32768;
    logic [15:0] cur_power = 16'd4096;

    logic [15:0] weight_q[$];
    bit          failed = 0;
    int          idle_pct = 0;
    int          quiet_cycles = 0;

    function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
        logic [63:0] root, probe;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= v) root = probe;
        end
        return root;
    endfunction

    // log2 of 1..65535, FRAC_BITS fraction bits, truncated
    function automatic longint log2_q(input logic [16:0] x);
        int          ex;
        logic [63:0] m;
        longint      frac;
        ex = 15;
        frac = 0;
        while (ex > 0 && !x[ex]) ex--;
        m = 64'(x) << (30 - ex);
        for (int i = 0; i < FRAC_BITS; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return longint'(ex) * 1024 + frac;
    endfunction

    function automatic logic [63:0] exp2_q(input logic [63:0] fk);
        logic [63:0] acc, root;
        acc = 64'd1 << 30;
        root = 64'd1 << 31;
        for (int k = 1; k <= FRAC_BITS; k++) begin
            root = sqrt_floor(root << 30);
            if (fk[FRAC_BITS-k]) acc = (acc * root + (64'd1 << 29)) >> 30;
        end
        return acc;
    endfunction

    // 1/(1+2^t), t with FRAC_BITS+12 fraction bits, result Q0.16
    function automatic logic [16:0] logistic_q16(input longint t);
        longint      n, ft;
        logic [63:0] ev, den;
        n = t >>> (FRAC_BITS + 12);
        ft = t - (n <<< (FRAC_BITS + 12));
        if (n > 31) return 17'd0;
        if (n < -32) n = -32;
        ev = exp2_q(64'(ft) >> 12);
        den = (n >= 0) ? (64'd1 << 30) + (ev << n) : (64'd1 << 30) + (ev >> (-n));
        return 17'(((64'd1 << 46) + den / 2) / den);
    endfunction

    function automatic logic [15:0] weight_for(input logic [16:0] prog);
        logic [16:0] p, loc, w;
        longint      pw, lo, hi, res, lsum;
        if (!cur_mode) return cur_fixed;
        p = (prog > Q16_ONE) ? Q16_ONE : prog;
        loc = (cur_mid > Q16_ONE) ? Q16_ONE : cur_mid;
        pw = longint'($signed(cur_power));
        lo = longint'($signed(cur_min));
        hi = longint'($signed(cur_max));
        if (p == 0 || loc == Q16_ONE) begin
            w = (pw > 0) ? 17'd0 : Q16_ONE;
        end else if (p == Q16_ONE || loc == 0) begin
            w = (pw > 0) ? Q16_ONE : (pw < 0) ? 17'd0 : 17'h08000;
        end else begin
            lsum = log2_q(loc) + log2_q(Q16_ONE - p) - log2_q(p) - log2_q(Q16_ONE - loc);
            w = logistic_q16(pw * lsum);
        end
        res = lo + ((longint'(w) * (hi - lo) + 32768) >>> 16);
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return res[15:0];
    endfunction

    // prediction on input transfer, register shadow on config transfer, result check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) weight_q.push_back(weight_for(i_progress));
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    spw_pkg::CFG_MODE:  cur_mode  <= i_cfg_data[0];
                    spw_pkg::CFG_FIXED: cur_fixed <= i_cfg_data[15:0];
                    spw_pkg::CFG_MIN:   cur_min   <= i_cfg_data[15:0];
                    spw_pkg::CFG_MAX:   cur_max   <= i_cfg_data[15:0];
                    spw_pkg::CFG_MID:   cur_mid   <= i_cfg_data;
                    spw_pkg::CFG_POW:   cur_power <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (o_weight_valid) begin
                if (weight_q.size() == 0) begin
                    $error("unexpected result: weight_out actual %0d", $signed(o_weight_out));
                    failed = 1;
                end else if (weight_q[0] != o_weight_out) begin
                    $error("weight_out mismatch: expected %0d actual %0d",
                           $signed(weight_q[0]), $signed(o_weight_out));
                    failed = 1;
                    void'(weight_q.pop_front());
                end else begin
                    void'(weight_q.pop_front());
                end
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_weight_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // each cycle idles with probability idle_pct percent
    task automatic send_progress(input logic [16:0] v);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_progress <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (weight_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
        drain();
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] pick_q16();
        case ($urandom_range(7))
            0: return 17'd0;
            1: return Q16_ONE;
            2: return 17'($urandom_range(65537, 131071));
            3: return 17'($urandom_range(1, 64));
            4: return 17'($urandom_range(65472, 65535));
            default: return 17'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic test_fixed_mode();
        write_reg(spw_pkg::CFG_MODE, 17'd0);
        write_reg(spw_pkg::CFG_FIXED, 17'h08000);
        send_progress(17'd0);
        send_progress(17'h1FFFF);
        write_reg(spw_pkg::CFG_FIXED, 17'h07FFF);
        send_progress(Q16_ONE);
        send_progress(17'd12345);
        write_reg(spw_pkg::CFG_MODE, 17'd1);
    endtask

    task automatic test_special_points();
        logic [16:0] pts[6] = '{17'd0, 17'd1, 17'd32768, 17'd65535, Q16_ONE, 17'h1FFFF};
        logic [15:0] pows[3] = '{16'd4096, 16'h0000, 16'hF000};
        foreach (pows[j]) begin
            write_reg(spw_pkg::CFG_POW, 17'(pows[j]));
            foreach (pts[i]) send_progress(pts[i]);
        end
        // midpoint at zero, above one and at its smallest step; huge exponents
        write_reg(spw_pkg::CFG_MID, 17'd0);
        send_progress(17'd20000);
        write_reg(spw_pkg::CFG_MID, 17'h1FFFF);
        send_progress(17'd20000);
        write_reg(spw_pkg::CFG_MID, 17'd1);
        write_reg(spw_pkg::CFG_POW, 17'h07FFF);
        send_progress(17'd65535);
        write_reg(spw_pkg::CFG_POW, 17'h08000);
        send_progress(17'd65535);
        write_reg(spw_pkg::CFG_MIN, 17'h08000);
        write_reg(spw_pkg::CFG_MAX, 17'h07FFF);
        send_progress(17'd1);
        write_reg(spw_pkg::CFG_RSVD6, 17'h1FFFF);
        write_reg(spw_pkg::CFG_RSVD7, 17'h15555);
        send_progress(17'd40000);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 9; ph++) begin
            idle_pct = (ph < 3) ? 12 : (ph < 6) ? 65 : 0;
            write_reg(spw_pkg::CFG_MODE, ($urandom_range(5) == 0) ? 17'd0 : 17'h1FFFF);
            write_reg(spw_pkg::CFG_FIXED, 17'(pick_word()));
            write_reg(spw_pkg::CFG_MIN, 17'(pick_word()));
            write_reg(spw_pkg::CFG_MAX, 17'(pick_word()));
            write_reg(spw_pkg::CFG_MID, pick_q16());
            write_reg(spw_pkg::CFG_POW, ($urandom_range(3) == 0) ? 17'(pick_word())
                                        : 17'($urandom_range(0, 32767) - 16384));
            for (int i = 0; i < 100; i++) begin
                send_progress(($urandom_range(3) == 0) ? pick_q16() : 17'($urandom));
                if (i == 50 && ph == 4) drain();   // sender waits for the pipeline to empty
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fixed_mode();
        test_special_points();
        test_random_phases();
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (!failed && weight_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            if (weight_q.size() != 0) $error("%0d results never arrived", weight_q.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
